// File: design/lbs_pkg.sv
// Shared definitions for the looper button scanner: sizes, register indexes,
// button phase and event codes, and the controller/datapath command and status types.
// Depends on nothing.
package lbs_pkg;

	localparam int NUM_BUTTONS = 8;
	localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int CNT_W = $clog2(NUM_BUTTONS + 1);
	localparam int LED_W = 8;
	localparam int LEVEL_W = 8;
	localparam int PAD_W = 8;
	localparam int KIND_W = 2;
	localparam int PHASE_W = 3;

	// The scan sequencer runs one remainder step per bit of the scan counter.
	localparam int COUNT_W = 16;
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_OFFSET = 1'b1;
	localparam logic [COUNT_W-1:0] RESET_TOGGLE_INTERVAL = 16'd250;
	localparam logic [PAD_W-1:0] RESET_PAD_OFFSET = 8'd46;

	localparam logic [PHASE_W-1:0] PH_UP_IDLE = 3'd0;
	localparam logic [PHASE_W-1:0] PH_DOWN_RECORD = 3'd1;
	localparam logic [PHASE_W-1:0] PH_UP_RECORD = 3'd2;
	localparam logic [PHASE_W-1:0] PH_DOWN_PLAY = 3'd3;
	localparam logic [PHASE_W-1:0] PH_UP_PLAY = 3'd4;
	localparam logic [PHASE_W-1:0] PH_DOWN_IDLE = 3'd5;

	localparam logic [KIND_W-1:0] EV_NONE = 2'd0;
	localparam logic [KIND_W-1:0] EV_RECORD_START = 2'd1;
	localparam logic [KIND_W-1:0] EV_PLAY_START = 2'd2;
	localparam logic [KIND_W-1:0] EV_PLAY_STOP = 2'd3;

	typedef struct packed {
		logic start;
		logic step;
		logic [STEP_W-1:0] step_idx;
		logic finish;
		logic emit;
		logic [CNT_W-1:0] emit_idx;
		logic emit_last;
	} lbs_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] ev_count;
		logic out_busy;
	} lbs_status_t;

endpackage

// File: design/lbs_in_if.sv
// Input channel of the looper button scanner: one scan of button levels.
// Depends on lbs_pkg.
interface lbs_in_if;
	logic valid;
	logic ready;
	logic [lbs_pkg::LEVEL_W-1:0] button_levels;

	modport source (output valid, output button_levels, input ready);
	modport sink (input valid, input button_levels, output ready);
endinterface

// File: design/lbs_out_if.sv
// Output channel of the looper button scanner: one event result per transaction.
// Depends on lbs_pkg.
interface lbs_out_if;
	logic valid;
	logic ready;
	logic [lbs_pkg::KIND_W-1:0] event_kind;
	logic [lbs_pkg::PAD_W-1:0] pad_number;
	logic [lbs_pkg::LED_W-1:0] led_levels;
	logic last_of_scan;

	modport source (output valid, output event_kind, output pad_number, output led_levels,
		output last_of_scan, input ready);
	modport sink (input valid, input event_kind, input pad_number, input led_levels,
		input last_of_scan, output ready);
endinterface

// File: design/lbs_ctrl.sv
// Controller of the looper button scanner: sequences a scan, its finish and
// the delivery of buffered results. Depends on lbs_pkg.
module lbs_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  lbs_pkg::lbs_status_t status,
	output lbs_pkg::lbs_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [lbs_pkg::STEP_W-1:0] step_q;
	logic [lbs_pkg::CNT_W-1:0] ptr_q;
	logic [lbs_pkg::CNT_W-1:0] ptr_inc;

	assign in_ready = (state_q == ST_IDLE);
	assign ptr_inc = ptr_q + 1'b1;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cmd.step_idx = step_q;
		cmd.emit_idx = ptr_q;
		cmd.emit_last = (ptr_inc >= status.ev_count);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (step_q == lbs_pkg::STEP_LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					if (cmd.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			ptr_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.finish) begin
				ptr_q <= '0;
			end else if (cmd.emit) begin
				ptr_q <= ptr_inc;
			end
		end
	end

endmodule

// File: design/lbs_dpath.sv
// Datapath of the looper button scanner: configuration registers, button phases,
// busy flag, blink remainder unit, event buffer and output register. Depends on lbs_pkg.
module lbs_dpath (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [lbs_pkg::LEVEL_W-1:0] in_levels,
	input  lbs_pkg::lbs_cmd_t cmd,
	output lbs_pkg::lbs_status_t status,
	input  logic out_ready,
	output logic out_valid,
	output logic [lbs_pkg::KIND_W-1:0] out_kind,
	output logic [lbs_pkg::PAD_W-1:0] out_pad,
	output logic [lbs_pkg::LED_W-1:0] out_led,
	output logic out_last
);

	logic [lbs_pkg::COUNT_W-1:0] toggle_interval_q;
	logic [lbs_pkg::PAD_W-1:0] pad_offset_q;
	logic [lbs_pkg::LEVEL_W-1:0] levels_q;
	logic [lbs_pkg::PHASE_W-1:0] phase_q [lbs_pkg::NUM_BUTTONS];
	logic busy_q;
	logic [lbs_pkg::COUNT_W-1:0] counter_q;
	logic [lbs_pkg::LED_W-1:0] led_q;
	logic [lbs_pkg::LED_W-1:0] toggle_q;
	logic [lbs_pkg::COUNT_W-1:0] rem_q;
	logic [lbs_pkg::KIND_W-1:0] kind_buf_q [lbs_pkg::NUM_BUTTONS];
	logic [lbs_pkg::PAD_W-1:0] pad_buf_q [lbs_pkg::NUM_BUTTONS];
	logic [lbs_pkg::CNT_W-1:0] ev_count_q;
	logic out_valid_q;
	logic [lbs_pkg::KIND_W-1:0] out_kind_q;
	logic [lbs_pkg::PAD_W-1:0] out_pad_q;
	logic [lbs_pkg::LED_W-1:0] out_led_q;
	logic out_last_q;

	logic [lbs_pkg::BTN_W-1:0] btn;
	logic visit;
	logic pressed;
	logic [lbs_pkg::PHASE_W-1:0] cur_phase;
	logic [lbs_pkg::PHASE_W-1:0] nxt_phase;
	logic busy_set;
	logic busy_clr;
	logic led_set;
	logic led_clr;
	logic tog;
	logic [lbs_pkg::KIND_W-1:0] ev;
	logic [lbs_pkg::LED_W-1:0] led_bit;

	logic [lbs_pkg::COUNT_W-1:0] divisor;
	logic [lbs_pkg::COUNT_W:0] shifted;
	logic [lbs_pkg::COUNT_W:0] diff;
	logic blink_now;

	assign btn = cmd.step_idx[lbs_pkg::BTN_W-1:0];
	assign visit = cmd.step &&
		({1'b0, cmd.step_idx} < (lbs_pkg::STEP_W + 1)'(lbs_pkg::NUM_BUTTONS));
	// Only the first eight buttons have a level input and an LED.
	assign pressed = !cmd.step_idx[3] && levels_q[cmd.step_idx[2:0]];
	assign led_bit = cmd.step_idx[3] ? '0 : (lbs_pkg::LED_W'(1) << cmd.step_idx[2:0]);
	assign cur_phase = phase_q[btn];

	always_comb begin
		nxt_phase = cur_phase;
		busy_set = 1'b0;
		busy_clr = 1'b0;
		led_set = 1'b0;
		led_clr = 1'b0;
		tog = 1'b0;
		ev = lbs_pkg::EV_NONE;
		case (cur_phase)
			lbs_pkg::PH_DOWN_RECORD: begin
				if (!pressed) begin
					nxt_phase = lbs_pkg::PH_UP_RECORD;
				end
			end
			lbs_pkg::PH_UP_RECORD: begin
				if (pressed) begin
					nxt_phase = lbs_pkg::PH_DOWN_PLAY;
					busy_clr = 1'b1;
					ev = lbs_pkg::EV_PLAY_START;
				end else begin
					tog = 1'b1;
				end
			end
			lbs_pkg::PH_DOWN_PLAY: begin
				if (!pressed) begin
					nxt_phase = lbs_pkg::PH_UP_PLAY;
					led_set = 1'b1;
				end
			end
			lbs_pkg::PH_UP_PLAY: begin
				if (pressed) begin
					nxt_phase = lbs_pkg::PH_DOWN_IDLE;
					ev = lbs_pkg::EV_PLAY_STOP;
				end
			end
			lbs_pkg::PH_DOWN_IDLE: begin
				if (!pressed) begin
					nxt_phase = lbs_pkg::PH_UP_IDLE;
					led_clr = 1'b1;
				end
			end
			default: begin
				if (!busy_q && pressed) begin
					nxt_phase = lbs_pkg::PH_DOWN_RECORD;
					busy_set = 1'b1;
					ev = lbs_pkg::EV_RECORD_START;
				end
			end
		endcase
	end

	// Restoring remainder of the scan counter by the blink period, one counter bit
	// per step, most significant bit first. A period of zero behaves as one.
	assign divisor = (toggle_interval_q == '0) ? lbs_pkg::COUNT_W'(1) : toggle_interval_q;
	assign shifted = {rem_q, counter_q[~cmd.step_idx]};
	assign diff = shifted - {1'b0, divisor};
	assign blink_now = (rem_q == '0);

	assign status.ev_count = ev_count_q;
	assign status.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_kind = out_kind_q;
	assign out_pad = out_pad_q;
	assign out_led = out_led_q;
	assign out_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_interval_q <= lbs_pkg::RESET_TOGGLE_INTERVAL;
			pad_offset_q <= lbs_pkg::RESET_PAD_OFFSET;
			for (int i = 0; i < lbs_pkg::NUM_BUTTONS; i++) begin
				phase_q[i] <= lbs_pkg::PH_UP_IDLE;
			end
			busy_q <= 1'b0;
			counter_q <= '0;
			led_q <= '0;
			ev_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lbs_pkg::CFG_TOGGLE_INTERVAL: toggle_interval_q <= cfg_wdata;
					lbs_pkg::CFG_PAD_OFFSET: pad_offset_q <= cfg_wdata[lbs_pkg::PAD_W-1:0];
					default: ;
				endcase
			end
			if (cmd.start) begin
				ev_count_q <= '0;
			end else if (visit) begin
				phase_q[btn] <= nxt_phase;
				if (busy_set) begin
					busy_q <= 1'b1;
				end else if (busy_clr) begin
					busy_q <= 1'b0;
				end
				if (led_set) begin
					led_q <= led_q | led_bit;
				end else if (led_clr) begin
					led_q <= led_q & ~led_bit;
				end
				if (ev != lbs_pkg::EV_NONE) begin
					ev_count_q <= ev_count_q + 1'b1;
				end
			end
			// Recording LEDs toggle together once the remainder is known.
			if (cmd.finish) begin
				if (blink_now) begin
					led_q <= led_q ^ toggle_q;
				end
				counter_q <= counter_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			levels_q <= in_levels;
			rem_q <= '0;
			toggle_q <= '0;
		end else if (cmd.step) begin
			rem_q <= diff[lbs_pkg::COUNT_W] ? shifted[lbs_pkg::COUNT_W-1:0] :
				diff[lbs_pkg::COUNT_W-1:0];
			if (visit && tog) begin
				toggle_q <= toggle_q | led_bit;
			end
		end
		if (visit && ev != lbs_pkg::EV_NONE) begin
			kind_buf_q[ev_count_q[lbs_pkg::BTN_W-1:0]] <= ev;
			pad_buf_q[ev_count_q[lbs_pkg::BTN_W-1:0]] <= pad_offset_q +
				lbs_pkg::PAD_W'(cmd.step_idx);
		end
		if (cmd.emit) begin
			if (ev_count_q == '0) begin
				out_kind_q <= lbs_pkg::EV_NONE;
				out_pad_q <= '0;
			end else begin
				out_kind_q <= kind_buf_q[cmd.emit_idx[lbs_pkg::BTN_W-1:0]];
				out_pad_q <= pad_buf_q[cmd.emit_idx[lbs_pkg::BTN_W-1:0]];
			end
			out_led_q <= led_q;
			out_last_q <= cmd.emit_last;
		end
	end

endmodule

// File: design/looper_button_scanner.sv
// Top level of the looper button scanner: controller, datapath and channel hookup.
// Depends on lbs_pkg, lbs_in_if, lbs_out_if, lbs_ctrl and lbs_dpath.

// Each input transaction is one scan of eight button levels. The scan visits one
// button per cycle while a bit-serial remainder unit works out whether the scan
// counter is a multiple of the blink period, one counter bit per cycle; that unit
// sets the scan length at one step per counter bit, followed by a finish state.
// The events of the scan (or a single "none" result) are then delivered one per
// cycle while the output side does not stall, from a small event buffer through
// an output register. The input is ready again once the last result is loaded
// into the output register, so a new scan is not taken before the last result of
// the previous one is loaded; a stalled result holds the scan.
// Configuration writes should be made only while no scan is in flight.
module looper_button_scanner (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	lbs_in_if.sink in_ch,
	lbs_out_if.source out_ch
);

	lbs_pkg::lbs_cmd_t cmd;
	lbs_pkg::lbs_status_t status;

	lbs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.status(status),
		.cmd(cmd)
	);

	lbs_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_levels(in_ch.button_levels),
		.cmd(cmd),
		.status(status),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.out_kind(out_ch.event_kind),
		.out_pad(out_ch.pad_number),
		.out_led(out_ch.led_levels),
		.out_last(out_ch.last_of_scan)
	);

endmodule

// File: design/lbs_checker.sv
// Port-level checks for the looper button scanner, bound to the top level.
// Depends on lbs_pkg and looper_button_scanner.
module lbs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [lbs_pkg::KIND_W-1:0] event_kind,
	input logic [lbs_pkg::PAD_W-1:0] pad_number,
	input logic [lbs_pkg::LED_W-1:0] led_levels,
	input logic last_of_scan
);

	// A scan is worked on alone: no second transaction right after one is taken.
	a_one_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	// A quiet scan gives a single result, so a none result ends its scan.
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == lbs_pkg::EV_NONE) |-> last_of_scan)
		else $error("none result is not last of scan");

	a_none_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == lbs_pkg::EV_NONE) |-> (pad_number == '0))
		else $error("none result carries a pad number");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(event_kind) &&
		$stable(pad_number) && $stable(led_levels) && $stable(last_of_scan)))
		else $error("stalled result changed");

endmodule

bind looper_button_scanner lbs_checker u_lbs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.event_kind(out_ch.event_kind),
	.pad_number(out_ch.pad_number),
	.led_levels(out_ch.led_levels),
	.last_of_scan(out_ch.last_of_scan)
);

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the looper button scanner: sends scans of button levels, predicts each
// scan's events and LED vector, and checks every result in order.
// Depends on lbs_pkg, lbs_in_if, lbs_out_if and looper_button_scanner.
module tb_top;

	localparam int TIMEOUT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_PCT = 27;

	typedef struct packed {
		logic [lbs_pkg::KIND_W-1:0] kind;
		logic [lbs_pkg::PAD_W-1:0] pad;
		logic [lbs_pkg::LED_W-1:0] leds;
		logic last;
	} scan_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lbs_pkg::CFG_DATA_W-1:0] cfg_wdata;

	lbs_in_if in_ch ();
	lbs_out_if out_ch ();

	looper_button_scanner i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Predicted scanner state and settings.
	logic [lbs_pkg::PHASE_W-1:0] btn_phase [lbs_pkg::NUM_BUTTONS];
	logic rec_busy;
	logic [lbs_pkg::COUNT_W-1:0] scan_count;
	logic [lbs_pkg::LED_W-1:0] led_state;
	logic [lbs_pkg::COUNT_W-1:0] toggle_interval;
	logic [lbs_pkg::PAD_W-1:0] pad_offset;

	scan_result_t pending_results [$];
	scan_result_t want;
	logic [lbs_pkg::LEVEL_W-1:0] prev_levels;
	int errors = 0;
	int scans_sent = 0;
	int results_seen = 0;
	int settings_used = 0;
	int cycle_count = 0;
	int hold_off = 0;
	bit no_gaps = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want_v,
		input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
			errors++;
		end
	endfunction

	// Walks the buttons in ascending order, so a busy flag change made by one button is
	// seen by the buttons after it in the same scan.
	function automatic void predict_scan(input logic [lbs_pkg::LEVEL_W-1:0] levels);
		logic [lbs_pkg::KIND_W-1:0] kinds [lbs_pkg::NUM_BUTTONS];
		logic [lbs_pkg::PAD_W-1:0] pads [lbs_pkg::NUM_BUTTONS];
		logic [lbs_pkg::COUNT_W-1:0] period;
		logic [lbs_pkg::KIND_W-1:0] ev;
		logic blink_now;
		logic pressed;
		scan_result_t r;
		int n;
		n = 0;
		period = (toggle_interval == '0) ? lbs_pkg::COUNT_W'(1) : toggle_interval;
		blink_now = (scan_count % period) == '0;
		for (int i = 0; i < lbs_pkg::NUM_BUTTONS; i++) begin
			pressed = levels[i];
			ev = lbs_pkg::EV_NONE;
			case (btn_phase[i])
				lbs_pkg::PH_DOWN_RECORD: begin
					if (!pressed)
						btn_phase[i] = lbs_pkg::PH_UP_RECORD;
				end
				lbs_pkg::PH_UP_RECORD: begin
					if (pressed) begin
						btn_phase[i] = lbs_pkg::PH_DOWN_PLAY;
						rec_busy = 1'b0;
						ev = lbs_pkg::EV_PLAY_START;
					end else if (blink_now) begin
						led_state[i] = ~led_state[i];
					end
				end
				lbs_pkg::PH_DOWN_PLAY: begin
					if (!pressed) begin
						btn_phase[i] = lbs_pkg::PH_UP_PLAY;
						led_state[i] = 1'b1;
					end
				end
				lbs_pkg::PH_UP_PLAY: begin
					if (pressed) begin
						btn_phase[i] = lbs_pkg::PH_DOWN_IDLE;
						ev = lbs_pkg::EV_PLAY_STOP;
					end
				end
				lbs_pkg::PH_DOWN_IDLE: begin
					if (!pressed) begin
						btn_phase[i] = lbs_pkg::PH_UP_IDLE;
						led_state[i] = 1'b0;
					end
				end
				default: begin
					if (!rec_busy && pressed) begin
						rec_busy = 1'b1;
						btn_phase[i] = lbs_pkg::PH_DOWN_RECORD;
						ev = lbs_pkg::EV_RECORD_START;
					end
				end
			endcase
			if (ev != lbs_pkg::EV_NONE) begin
				kinds[n] = ev;
				pads[n] = pad_offset + lbs_pkg::PAD_W'(i);
				n++;
			end
		end
		scan_count = scan_count + 1'b1;
		if (n == 0) begin
			kinds[0] = lbs_pkg::EV_NONE;
			pads[0] = '0;
			n = 1;
		end
		for (int k = 0; k < n; k++) begin
			r.kind = kinds[k];
			r.pad = pads[k];
			r.leds = led_state;
			r.last = (k == n - 1);
			pending_results.push_back(r);
		end
	endfunction

	// Result checker and output-side ready driver.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d pad %0d leds %h",
					$time, out_ch.event_kind, out_ch.pad_number, out_ch.led_levels);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("event_kind", want.kind, out_ch.event_kind);
				check_field("pad_number", want.pad, out_ch.pad_number);
				check_field("led_levels", want.leds, out_ch.led_levels);
				check_field("last_of_scan", want.last, out_ch.last_of_scan);
			end
		end
		if (hold_off > 0) begin
			out_ch.ready <= 1'b0;
			hold_off--;
		end else begin
			out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic send_scan(input logic [lbs_pkg::LEVEL_W-1:0] levels);
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.button_levels <= levels;
		do @(posedge clk); while (!in_ch.ready);
		predict_scan(levels);
		prev_levels = levels;
		scans_sent++;
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Both registers are written back to back; the block must be idle.
	task automatic configure(input logic [lbs_pkg::COUNT_W-1:0] period,
		input logic [lbs_pkg::PAD_W-1:0] offset);
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		cfg_we <= 1'b1;
		cfg_index <= lbs_pkg::CFG_TOGGLE_INTERVAL;
		cfg_wdata <= period;
		@(posedge clk);
		cfg_index <= lbs_pkg::CFG_PAD_OFFSET;
		cfg_wdata <= {junk, offset};
		@(posedge clk);
		cfg_we <= 1'b0;
		toggle_interval = period;
		pad_offset = offset;
		settings_used++;
	endtask

	task automatic run_random(input int count, input int flip_pct);
		logic [lbs_pkg::LEVEL_W-1:0] levels;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 15) begin
				levels = lbs_pkg::LEVEL_W'($urandom_range(0, 255));
			end else begin
				// Mostly slow changes, so buttons walk the full press/release cycle.
				levels = prev_levels;
				for (int b = 0; b < lbs_pkg::LEVEL_W; b++)
					if ($urandom_range(0, 99) < flip_pct)
						levels[b] = ~levels[b];
			end
			send_scan(levels);
		end
	endtask

	task automatic test_reset_defaults();
		send_scan(8'h00);
		send_scan(8'hFF);
		send_scan(8'hFE);
		send_scan(8'h00);
		wait_idle();
	endtask

	// Hands recording from button to button until all eight play, then stops them all
	// in one scan. The offset makes the upper pad numbers wrap.
	task automatic test_full_chain();
		configure(16'd1, 8'd250);
		send_scan(8'h01);
		send_scan(8'h00);
		for (int b = 0; b < lbs_pkg::NUM_BUTTONS - 1; b++) begin
			send_scan(lbs_pkg::LEVEL_W'(3) << b);
			send_scan(8'h00);
		end
		send_scan(8'h80);
		send_scan(8'h00);
		send_scan(8'hFF);
		send_scan(8'h00);
		wait_idle();
	endtask

	task automatic test_zero_period();
		configure(16'd0, 8'd255);
		run_random(35, 30);
		wait_idle();
	endtask

	task automatic test_steady_flow();
		configure(16'd3, 8'd0);
		no_gaps = 1'b1;
		run_random(30, 25);
		wait_idle();
		no_gaps = 1'b0;
	endtask

	// The output side holds off long enough for the input to stall, then the sender
	// pauses until every result is back before it carries on.
	task automatic test_output_stall();
		configure(16'hFFFF, 8'd248);
		hold_off = 250;
		run_random(20, 30);
		wait_idle();
		run_random(15, 30);
		wait_idle();
	endtask

	task automatic test_mixed();
		configure(16'd2, 8'd17);
		run_random(40, 20);
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.button_levels = '0;
		out_ch.ready = 1'b0;
		for (int i = 0; i < lbs_pkg::NUM_BUTTONS; i++)
			btn_phase[i] = lbs_pkg::PH_UP_IDLE;
		rec_busy = 1'b0;
		scan_count = '0;
		led_state = '0;
		toggle_interval = lbs_pkg::RESET_TOGGLE_INTERVAL;
		pad_offset = lbs_pkg::RESET_PAD_OFFSET;
		prev_levels = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_full_chain();
		test_zero_period();
		test_steady_flow();
		test_output_stall();
		test_mixed();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d scans and %0d results over %0d register settings,",
			scans_sent, results_seen, settings_used + 1);
		$display("including eight-event scans, pad wrap, output stalls and sender pauses.");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
